FILE: sv/assert_macros.svh
// Concurrent assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/sle_pkg.sv
package sle_pkg;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_READ     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_FIND     = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_RM_EQ    = 3'd6,
    OP_RM_RANGE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    op_t                op;
    logic               walk;  // needs a pass over the stored entries
    logic [3:0]         position;
    logic signed [31:0] operand;
    logic signed [31:0] bound_high;
  } req_t;

endpackage

FILE: sv/sle_front.sv
module sle_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         action,
  input  logic [3:0]         position,
  input  logic signed [31:0] operand,
  input  logic signed [31:0] bound_high,
  input  logic               q_full,
  output logic               busy,
  output logic               push,
  output sle_pkg::req_t      req
);
  import sle_pkg::*;

  logic  vld;
  logic  vld_next;
  logic  accept;
  op_t   op_dec;

  assign busy   = vld & q_full;
  assign push   = vld & ~q_full;
  assign accept = start & ~busy;
  assign op_dec = op_t'(action);

  always_comb begin
    vld_next = vld;
    if (accept) begin
      vld_next = 1'b1;
    end else if (push) begin
      vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.op         <= op_dec;
      req.walk       <= (op_dec == OP_DELETE) || (op_dec == OP_FIND) ||
                        (op_dec == OP_RM_EQ)  || (op_dec == OP_RM_RANGE);
      req.position   <= position;
      req.operand    <= operand;
      req.bound_high <= bound_high;
    end
  end

endmodule

FILE: sv/sle_queue.sv
module sle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sle_pkg::req_t push_req,
  input  logic          pop,
  output sle_pkg::req_t head,
  output logic          empty,
  output logic          full
);
  import sle_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  req_t           slot [QUEUE_DEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QCW-1:0] fill;
  logic           do_push;
  logic           do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == QCW'(QUEUE_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : wp + QAW'(1);
      end
      if (do_pop) begin
        rp <= (rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : rp + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + QCW'(1);
        2'b01:   fill <= fill - QCW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= push_req;
    end
  end

endmodule

FILE: sv/sle_back.sv
`include "assert_macros.svh"

module sle_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sle_pkg::req_t      head,
  output logic               pop,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic [3:0]         found_index,
  output logic [4:0]         removed_count,
  output logic [4:0]         length
);
  import sle_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t             state, state_next;
  req_t               cur, cur_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      rd_ptr, rd_ptr_next;
  logic [CW-1:0]      wr_ptr, wr_ptr_next;
  logic [CW-1:0]      pend_idx, pend_idx_next;
  logic               pend, pend_next;

  logic               done_next;
  status_t            status_r, status_next;
  logic signed [31:0] rval_next;
  logic [3:0]         fidx_next;
  logic [4:0]         rem_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  logic               head_in_range;
  logic               issue;
  logic               drop;

  assign head_in_range = CMPW'(head.position) < CMPW'(cnt);
  assign issue         = rd_ptr < cnt;

  always_comb begin
    case (cur.op)
      OP_DELETE:   drop = (pend_idx == CW'(cur.position));
      OP_RM_EQ:    drop = (rdata == cur.operand);
      OP_RM_RANGE: drop = (rdata > cur.operand) && (rdata < cur.bound_high);
      default:     drop = 1'b0;
    endcase
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    cnt_next      = cnt;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    pend_idx_next = pend_idx;
    pend_next     = pend;
    pop           = 1'b0;
    done_next     = 1'b0;
    status_next   = status_r;
    rval_next     = read_value;
    fidx_next     = found_index;
    rem_next      = removed_count;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = head.operand;

    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          pop         = 1'b1;
          cur_next    = head;
          status_next = ST_OK;
          rval_next   = '0;
          fidx_next   = '0;
          rem_next    = '0;
          if (head.walk) begin
            if (head.op == OP_DELETE && cnt == '0) begin
              done_next   = 1'b1;
              status_next = ST_EMPTY;
            end else if (head.op == OP_DELETE && !head_in_range) begin
              done_next   = 1'b1;
              status_next = ST_RANGE;
            end else begin
              state_next  = S_WALK;
              pend_next   = 1'b0;
              rd_ptr_next = (head.op == OP_DELETE) ? CW'(head.position) : '0;
              wr_ptr_next = (head.op == OP_DELETE) ? CW'(head.position) : '0;
            end
          end else begin
            case (head.op)
              OP_APPEND: begin
                done_next = 1'b1;
                if (cnt == CW'(DEPTH)) begin
                  status_next = ST_FULL;
                end else begin
                  mem_we   = 1'b1;
                  waddr    = cnt[AW-1:0];
                  cnt_next = cnt + CW'(1);
                end
              end
              OP_READ: begin
                if (!head_in_range) begin
                  done_next   = 1'b1;
                  status_next = ST_RANGE;
                end else begin
                  mem_re     = 1'b1;
                  raddr      = AW'(head.position);
                  state_next = S_READ;
                end
              end
              OP_WRITE: begin
                done_next = 1'b1;
                if (!head_in_range) begin
                  status_next = ST_RANGE;
                end else begin
                  mem_we = 1'b1;
                  waddr  = AW'(head.position);
                end
              end
              OP_CLEAR: begin
                done_next = 1'b1;
                cnt_next  = '0;
              end
              default: begin
                done_next = 1'b1;
              end
            endcase
          end
        end
      end
      S_READ: begin
        done_next  = 1'b1;
        rval_next  = rdata;
        state_next = S_IDLE;
      end
      S_WALK: begin
        pend_next = issue;
        if (issue) begin
          mem_re        = 1'b1;
          raddr         = rd_ptr[AW-1:0];
          rd_ptr_next   = rd_ptr + CW'(1);
          pend_idx_next = rd_ptr;
        end
        if (pend) begin
          if (cur.op == OP_FIND) begin
            if (rdata == cur.operand) begin
              done_next   = 1'b1;
              fidx_next   = 4'(pend_idx);
              state_next  = S_IDLE;
            end
          end else if (!drop) begin
            mem_we      = 1'b1;
            waddr       = wr_ptr[AW-1:0];
            wdata       = rdata;
            wr_ptr_next = wr_ptr + CW'(1);
          end
        end else if (!issue) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (cur.op == OP_FIND) begin
            status_next = ST_NOT_FOUND;
          end else begin
            cnt_next = wr_ptr;
            rem_next = 5'(cnt - wr_ptr);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur           <= cur_next;
    rd_ptr        <= rd_ptr_next;
    wr_ptr        <= wr_ptr_next;
    pend_idx      <= pend_idx_next;
    status_r      <= status_next;
    read_value    <= rval_next;
    found_index   <= fidx_next;
    removed_count <= rem_next;
    if (done_next) begin
      length <= 5'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  assign status = status_r;

  `ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(DEPTH))
  `ASSERT_IMP(a_walk_order, clk, rst, state == S_WALK && mem_we, wr_ptr < rd_ptr)
  `ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `ASSERT_NXT(a_append_grow, clk, rst,
              state == S_IDLE && pop && head.op == OP_APPEND && cnt != CW'(DEPTH),
              cnt == $past(cnt) + CW'(1))

endmodule

FILE: sv/sequential_list_engine.sv
// Channel   Handshake         Fields
// request   start / busy      action, position, operand, bound_high
// result    done (strobe)     status, read_value, found_index, removed_count, length
//
// Append, write, clear and rejected requests: start is registered in the front register,
// queued, and done is set from S_IDLE. Read: done comes from S_READ; the entry memory has
// a registered read port. Delete, find, remove: a walk in S_WALK from the start index,
// one entry per cycle through the entry memory, find stops at its first match.
// rst (synchronous) empties the list and the request queue; entries stay unset.
// busy while the two-entry queue and the front register are full; done is never held off.
module sequential_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [3:0]         position,
  input  logic signed [31:0] operand,
  input  logic signed [31:0] bound_high,
  output logic               done,
  output logic [2:0]         status,
  output logic signed [31:0] read_value,
  output logic [3:0]         found_index,
  output logic [4:0]         removed_count,
  output logic [4:0]         length
);
  import sle_pkg::*;

  req_t front_req;
  req_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  sle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .position   (position),
    .operand    (operand),
    .bound_high (bound_high),
    .q_full     (q_full),
    .busy       (busy),
    .push       (push),
    .req        (front_req)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (front_req),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sle_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .done          (done),
    .status        (status),
    .read_value    (read_value),
    .found_index   (found_index),
    .removed_count (removed_count),
    .length        (length)
  );

endmodule

FILE: bench/list_result_checker.sv
`timescale 1ns / 100ps

module list_result_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         action,
  input  logic [3:0]         position,
  input  logic signed [31:0] operand,
  input  logic signed [31:0] bound_high,
  input  logic               done,
  input  logic [2:0]         status,
  input  logic signed [31:0] read_value,
  input  logic [3:0]         found_index,
  input  logic [4:0]         removed_count,
  input  logic [4:0]         length,
  output int                 fail_count,
  output int                 outstanding
);
  import sle_pkg::*;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [3:0]         found_index;
    logic [4:0]         removed_count;
    logic [4:0]         length;
  } list_outcome_t;

  logic signed [31:0] mirror_entries [DEPTH];
  int                 mirror_len;
  list_outcome_t      awaited_outcomes [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mirror_len  = 0;
  end

  task automatic apply_list_request(input op_t op, input logic [3:0] pos,
                                    input logic signed [31:0] val,
                                    input logic signed [31:0] hi,
                                    output list_outcome_t res);
    int  kept;
    bit  drop;
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (mirror_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          mirror_entries[mirror_len] = val;
          mirror_len++;
        end
      end
      OP_DELETE: begin
        if (mirror_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= mirror_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int k = pos; k + 1 < mirror_len; k++) mirror_entries[k] = mirror_entries[k + 1];
          mirror_len--;
          res.removed_count = 5'd1;
        end
      end
      OP_READ: begin
        if (pos >= mirror_len) res.status = ST_RANGE;
        else res.read_value = mirror_entries[pos];
      end
      OP_WRITE: begin
        if (pos >= mirror_len) res.status = ST_RANGE;
        else mirror_entries[pos] = val;
      end
      OP_FIND: begin
        res.status = ST_NOT_FOUND;
        for (int k = 0; k < mirror_len; k++) begin
          if (res.status == ST_NOT_FOUND && mirror_entries[k] == val) begin
            res.status      = ST_OK;
            res.found_index = 4'(k);
          end
        end
      end
      OP_CLEAR: begin
        mirror_len = 0;
      end
      default: begin
        // remove equal / remove range: compact in order
        kept = 0;
        for (int k = 0; k < mirror_len; k++) begin
          if (op == OP_RM_EQ) drop = (mirror_entries[k] == val);
          else drop = (mirror_entries[k] > val) && (mirror_entries[k] < hi);
          if (!drop) begin
            mirror_entries[kept] = mirror_entries[k];
            kept++;
          end
        end
        res.removed_count = 5'(mirror_len - kept);
        mirror_len        = kept;
      end
    endcase
    res.length = 5'(mirror_len);
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    list_outcome_t predicted;
    list_outcome_t oldest;
    if (!rst) begin
      if (start && !busy) begin
        apply_list_request(op_t'(action), position, operand, bound_high, predicted);
        awaited_outcomes.push_back(predicted);
      end
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with no request outstanding, status %0d, length %0d",
                   $time, status, length);
          fail_count++;
        end else begin
          oldest = awaited_outcomes.pop_front();
          check_field("status", oldest.status, status);
          check_field("read_value", oldest.read_value, read_value);
          check_field("found_index", oldest.found_index, found_index);
          check_field("removed_count", oldest.removed_count, removed_count);
          check_field("length", oldest.length, length);
        end
      end
    end
    outstanding <= awaited_outcomes.size();
  end

endmodule

FILE: bench/sequential_list_engine_tb.sv
`timescale 1ns / 100ps

module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 550;
  localparam int CYCLE_LIMIT = 300000;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic               busy;
  op_t                action     = OP_APPEND;
  logic [3:0]         position   = '0;
  logic signed [31:0] operand    = '0;
  logic signed [31:0] bound_high = '0;
  logic               done;
  logic [2:0]         status;
  logic signed [31:0] read_value;
  logic [3:0]         found_index;
  logic [4:0]         removed_count;
  logic [4:0]         length;
  int                 fail_count;
  int                 outstanding;
  int                 cycles     = 0;
  bit                 steady     = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sequential_list_engine #(.DEPTH(DEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .position     (position),
    .operand      (operand),
    .bound_high   (bound_high),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .found_index  (found_index),
    .removed_count(removed_count),
    .length       (length)
  );

  list_result_checker #(.DEPTH(DEPTH)) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .position     (position),
    .operand      (operand),
    .bound_high   (bound_high),
    .done         (done),
    .status       (status),
    .read_value   (read_value),
    .found_index  (found_index),
    .removed_count(removed_count),
    .length       (length),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drives one request and returns at the edge that accepts it.
  task automatic issue(input op_t op, input logic [3:0] pos,
                       input logic signed [31:0] val, input logic signed [31:0] hi);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= op;
    position   <= pos;
    operand    <= val;
    bound_high <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Small pool of repeated values so find and remove actually hit.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 40) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh8000_0001;
      2: return -32'sd5;
      3: return -32'sd1;
      4: return 32'sd0;
      5: return 32'sd1;
      6: return 32'sd7;
      default: return 32'sh7fff_ffff;
    endcase
  endfunction

  // trend 0 grows the list, 1 shrinks it, 2 keeps it mixed
  function automatic op_t choose_op(input int trend);
    int r;
    int grow_w;
    int cut_w;
    r      = $urandom_range(0, 99);
    grow_w = (trend == 0) ? 55 : (trend == 1) ? 20 : 35;
    cut_w  = (trend == 0) ? 8 : (trend == 1) ? 40 : 20;
    if (r < grow_w) return OP_APPEND;
    r -= grow_w;
    if (r < cut_w) begin
      case (r % 3)
        0: return OP_DELETE;
        1: return OP_RM_EQ;
        default: return OP_RM_RANGE;
      endcase
    end
    r -= cut_w;
    if (r < 3) return OP_CLEAR;
    case (r % 3)
      0: return OP_READ;
      1: return OP_WRITE;
      default: return OP_FIND;
    endcase
  endfunction

  initial begin
    int                 trend;
    op_t                op;
    logic [3:0]         pos;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] tmp;
    logic signed [31:0] fill;
    trend = 2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list
    issue(OP_DELETE, 4'd0, 32'sd0, 32'sd0);
    issue(OP_READ, 4'd0, 32'sd0, 32'sd0);
    issue(OP_FIND, 4'd0, 32'sd0, 32'sd0);
    // fill to full with extremes and duplicates
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: fill = 32'sh8000_0000;
        1: fill = 32'sh7fff_ffff;
        2, 4: fill = -32'sd1;
        3: fill = 32'sd0;
        5: fill = 32'sd1;
        default: fill = $urandom;
      endcase
      issue(OP_APPEND, 4'd0, fill, 32'sd0);
    end
    issue(OP_APPEND, 4'd0, 32'sd9, 32'sd0);
    issue(OP_READ, 4'd15, 32'sd0, 32'sd0);
    issue(OP_WRITE, 4'd3, 32'sh5555_5555, 32'sd0);
    issue(OP_FIND, 4'd0, 32'sh7fff_ffff, 32'sd0);
    issue(OP_RM_EQ, 4'd0, -32'sd1, 32'sd0);
    issue(OP_RM_RANGE, 4'd0, 32'sd5, 32'sd5);
    issue(OP_RM_RANGE, 4'd0, -32'sd10, 32'sd10);
    issue(OP_DELETE, 4'd0, 32'sd0, 32'sd0);
    issue(OP_CLEAR, 4'd0, 32'sd0, 32'sd0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 50 == 0) trend = $urandom_range(0, 2);
      steady = (n >= 200 && n < 320);
      op     = choose_op(trend);
      lo     = pick_value();
      hi     = pick_value();
      if (op == OP_RM_RANGE && lo > hi && $urandom_range(0, 9) < 7) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      pos = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
      issue(op, pos, lo, hi);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
